// ===== rtl/lltx_pkg.sv =====
// Package: shared types, constants and helpers of the LLDP transmit state machine.
`default_nettype none

package lltx_pkg;

    localparam int unsigned C_TIMER_W   = 16;
    localparam int unsigned C_HOLD_W    = 8;
    localparam int unsigned C_ADMIN_W   = 2;
    localparam int unsigned C_CFG_IDX_W = 8;
    localparam int unsigned C_CFG_DAT_W = 16;
    localparam int unsigned C_PROD_W    = C_TIMER_W + C_HOLD_W;

    // Advertised TTL ceiling.
    localparam logic [C_TIMER_W-1:0] C_TTL_MAX = 16'hFFFF;

    // Register reset values.
    localparam logic [C_TIMER_W-1:0] C_RST_REFRESH = 16'd5;
    localparam logic [C_HOLD_W-1:0]  C_RST_HOLD    = 8'd4;
    localparam logic [C_TIMER_W-1:0] C_RST_DELAY   = 16'd2;
    localparam logic [C_TIMER_W-1:0] C_RST_REINIT  = 16'd2;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_W-1:0] C_REG_REFRESH = 8'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_HOLD    = 8'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DELAY   = 8'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_REINIT  = 8'd3;

    // Admin status codes.
    localparam logic [C_ADMIN_W-1:0] C_ADMIN_DISABLED = 2'd0;
    localparam logic [C_ADMIN_W-1:0] C_ADMIN_RX_ONLY  = 2'd1;
    localparam logic [C_ADMIN_W-1:0] C_ADMIN_TX_ONLY  = 2'd2;
    localparam logic [C_ADMIN_W-1:0] C_ADMIN_RX_TX    = 2'd3;

    typedef enum logic [1:0] {
        ST_INIT = 2'd0,
        ST_IDLE = 2'd1,
        ST_SHUT = 2'd2,
        ST_INFO = 2'd3
    } t_tx_state;

    typedef struct packed {
        logic [C_TIMER_W-1:0] refresh_interval;
        logic [C_HOLD_W-1:0]  hold_multiplier;
        logic [C_TIMER_W-1:0] min_tx_delay;
        logic [C_TIMER_W-1:0] reinit_hold;
        logic [C_TIMER_W-1:0] ttl_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           fsm_state;
        logic                 send_info;
        logic                 send_shutdown;
        logic [C_TIMER_W-1:0] ttl_value;
    } t_result;

    function automatic logic [C_TIMER_W-1:0] f_dec_sat(input logic [C_TIMER_W-1:0] t);
        return (t != '0) ? (t - {{(C_TIMER_W-1){1'b0}}, 1'b1}) : '0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lltx_intf.sv =====
// Interfaces: tick request, result request and configuration write channels.
`default_nettype none

interface lltx_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] admin_status;
    logic       local_change;

    modport source (output valid, output admin_status, output local_change, input ready);
    modport sink   (input valid, input admin_status, input local_change, output ready);
endinterface

interface lltx_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fsm_state_out;
    logic        send_info;
    logic        send_shutdown;
    logic [15:0] ttl_value;

    modport source (output valid, output fsm_state_out, output send_info,
                    output send_shutdown, output ttl_value, input ready);
    modport sink   (input valid, input fsm_state_out, input send_info,
                    input send_shutdown, input ttl_value, output ready);
endinterface

interface lltx_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lltx_cfg_regs.sv =====
// Configuration registers and the capped TTL product derived from them.
`default_nettype none

module lltx_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [lltx_pkg::C_CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [lltx_pkg::C_CFG_DAT_W-1:0] i_wr_data,
    output      lltx_pkg::t_cfg                   o_cfg
);
    import lltx_pkg::*;

    logic [C_TIMER_W-1:0] r_refresh;
    logic [C_HOLD_W-1:0]  r_hold;
    logic [C_TIMER_W-1:0] r_delay;
    logic [C_TIMER_W-1:0] r_reinit;
    logic [C_PROD_W-1:0]  w_prod;
    logic [C_PROD_W-1:0]  w_ttl_max_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh <= C_RST_REFRESH;
            r_hold    <= C_RST_HOLD;
            r_delay   <= C_RST_DELAY;
            r_reinit  <= C_RST_REINIT;
        end else if (i_wr_en) begin
            case (i_wr_index)
                C_REG_REFRESH: r_refresh <= i_wr_data[C_TIMER_W-1:0];
                C_REG_HOLD:    r_hold    <= i_wr_data[C_HOLD_W-1:0];
                C_REG_DELAY:   r_delay   <= i_wr_data[C_TIMER_W-1:0];
                C_REG_REINIT:  r_reinit  <= i_wr_data[C_TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate interval times hold at the TTL ceiling.
    assign w_prod        = {{C_HOLD_W{1'b0}}, r_refresh} * {{C_TIMER_W{1'b0}}, r_hold};
    assign w_ttl_max_ext = {{C_HOLD_W{1'b0}}, C_TTL_MAX};

    always_comb begin
        o_cfg.refresh_interval = r_refresh;
        o_cfg.hold_multiplier  = r_hold;
        o_cfg.min_tx_delay     = r_delay;
        o_cfg.reinit_hold      = r_reinit;
        o_cfg.ttl_limit        = (w_prod < w_ttl_max_ext) ? w_prod[C_TIMER_W-1:0] : C_TTL_MAX;
    end

endmodule

`default_nettype wire

// ===== rtl/lltx_core.sv =====
// Transmit state machine, change latch, down-counters and latched TTL.
`default_nettype none

module lltx_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic [lltx_pkg::C_ADMIN_W-1:0] i_admin_status,
    input  wire logic                           i_local_change,
    input  wire lltx_pkg::t_cfg                 i_cfg,
    output      lltx_pkg::t_result              o_result
);
    import lltx_pkg::*;

    t_tx_state            r_state, n_state;
    logic [C_TIMER_W-1:0] r_refresh, n_refresh;
    logic [C_TIMER_W-1:0] r_delay, n_delay;
    logic [C_TIMER_W-1:0] r_shut, n_shut;
    logic                 r_latch, n_latch;
    logic [C_TIMER_W-1:0] r_ttl, n_ttl;

    logic w_tx_on;
    logic w_latch_in;
    logic w_enter_idle;
    logic w_enter_shut;
    logic w_enter_info;

    assign w_tx_on    = (i_admin_status == C_ADMIN_TX_ONLY) || (i_admin_status == C_ADMIN_RX_TX);
    assign w_latch_in = r_latch | i_local_change;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (w_tx_on) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (!w_tx_on) begin
                    n_state = ST_SHUT;
                end else if ((r_delay == '0) && ((r_refresh == '0) || w_latch_in)) begin
                    n_state = ST_INFO;
                end
            end
            ST_SHUT: begin
                if (r_shut == '0) n_state = ST_INIT;
            end
            ST_INFO: n_state = ST_IDLE;
            default: n_state = ST_INIT;
        endcase
    end

    // Actions and counter updates.
    always_comb begin
        w_enter_idle = ((r_state == ST_INIT) && w_tx_on) || (r_state == ST_INFO);
        w_enter_shut = (r_state == ST_IDLE) && (n_state == ST_SHUT);
        w_enter_info = (r_state == ST_IDLE) && (n_state == ST_INFO);

        n_refresh = f_dec_sat(w_enter_idle ? i_cfg.refresh_interval : r_refresh);
        n_delay   = f_dec_sat(w_enter_idle ? i_cfg.min_tx_delay : r_delay);

        if (w_enter_shut) begin
            n_shut = f_dec_sat(i_cfg.reinit_hold);
        end else if (n_state == ST_INIT) begin
            n_shut = '0;
        end else begin
            n_shut = f_dec_sat(r_shut);
        end

        n_latch = (w_enter_idle || (n_state == ST_INIT)) ? 1'b0 : w_latch_in;
        n_ttl   = w_enter_idle ? i_cfg.ttl_limit : r_ttl;

        o_result.fsm_state     = n_state;
        o_result.send_info     = w_enter_info;
        o_result.send_shutdown = w_enter_shut;
        o_result.ttl_value     = n_ttl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_refresh <= '0;
            r_delay   <= '0;
            r_shut    <= '0;
            r_latch   <= 1'b0;
            r_ttl     <= '0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_refresh <= n_refresh;
            r_delay   <= n_delay;
            r_shut    <= n_shut;
            r_latch   <= n_latch;
            r_ttl     <= n_ttl;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lldp_transmit_fsm.sv =====
// Top level: LLDP transmit state machine with input and result registers.
//
//  channel   dir  modport  payload                                          request
//  i_tick    in   sink     admin_status[1:0], local_change                  one timer tick
//  o_result  out  source   fsm_state_out[1:0], send_info, send_shutdown,
//                          ttl_value[15:0]                                  one per tick
//  i_cfg     in   sink     index[7:0], data[15:0]                           register write
//
// Every tick request yields exactly one result request. A tick waits in the input
// register; the state update runs between that register and the result register,
// so the result is loaded as its tick leaves the input register. One tick is taken
// per cycle while the result side keeps up. The state machine and its counters
// advance only when the result register can take a new value.
// Synchronous active-low reset clears state, counters and both valid flags and
// loads the register defaults. Configuration writes are always accepted.
`default_nettype none

module lldp_transmit_fsm (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lltx_tick_if.sink    i_tick,
    lltx_result_if.source o_result,
    lltx_cfg_if.sink     i_cfg
);
    import lltx_pkg::*;

    // Input register.
    logic                 r_in_valid;
    logic [C_ADMIN_W-1:0] r_in_admin;
    logic                 r_in_change;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic    w_step;
    logic    w_in_take;
    t_cfg    w_cfg;
    t_result w_core_result;

    // Advance the held tick when the result register is empty or being drained.
    assign w_step       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_step;
    assign w_in_take    = i_tick.valid && i_tick.ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    // Payload needs no reset; capture only on a taken request.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_admin  <= i_tick.admin_status;
            r_in_change <= i_tick.local_change;
        end
    end

    lltx_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid && i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    lltx_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_admin_status (r_in_admin),
        .i_local_change (r_in_change),
        .i_cfg          (w_cfg),
        .o_result       (w_core_result)
    );

    // Hold the result until the sink takes it; load a new one on each step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_core_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.fsm_state_out = r_out.fsm_state;
    assign o_result.send_info     = r_out.send_info;
    assign o_result.send_shutdown = r_out.send_shutdown;
    assign o_result.ttl_value     = r_out.ttl_value;

endmodule

`default_nettype wire

// ===== rtl/lltx_checker.sv =====
// Checker: port-level properties of the transmit state machine, bound to the top.
`default_nettype none

module lltx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_state,
    input wire logic        i_send_info,
    input wire logic        i_send_shutdown,
    input wire logic [15:0] i_ttl_value
);
    import lltx_pkg::*;

    // Never both frame pulses in one result.
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_send_info && i_send_shutdown))
        else $error("send_info and send_shutdown both raised");

    // An info pulse always reports the info-frame state.
    a_info_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_send_info) |-> (i_state == ST_INFO))
        else $error("send_info outside info-frame state");

    // A shutdown pulse always reports the shutdown-frame state.
    a_shut_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_send_shutdown) |-> (i_state == ST_SHUT))
        else $error("send_shutdown outside shutdown-frame state");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_state) && $stable(i_send_info) &&
             $stable(i_send_shutdown) && $stable(i_ttl_value)))
        else $error("stalled result changed");

endmodule

bind lldp_transmit_fsm lltx_checker u_lltx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_state         (o_result.fsm_state_out),
    .i_send_info     (o_result.send_info),
    .i_send_shutdown (o_result.send_shutdown),
    .i_ttl_value     (o_result.ttl_value)
);

`default_nettype wire

// ===== dv/lltx_checker.sv =====
// Checker: predicts LLDP transmit results from observed ticks and compares them.
`default_nettype none

module lltx_scoreboard (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lltx_tick_if        i_tick,
    lltx_result_if      i_result,
    lltx_cfg_if         i_cfg,
    output int unsigned o_pending,
    output int unsigned o_fail_count
);
    import lltx_pkg::*;

    // Shadow configuration.
    logic [C_TIMER_W-1:0] refresh_ivl;
    logic [C_HOLD_W-1:0]  hold_mult;
    logic [C_TIMER_W-1:0] min_delay;
    logic [C_TIMER_W-1:0] reinit_ticks;

    // Shadow state machine.
    t_tx_state            tx_state;
    logic [C_TIMER_W-1:0] refresh_left;
    logic [C_TIMER_W-1:0] delay_left;
    logic [C_TIMER_W-1:0] shut_left;
    logic                 change_seen;
    logic [C_TIMER_W-1:0] ttl_adv;

    t_result     predicted_results[$];
    int unsigned mismatches;

    function automatic void clear_state();
        refresh_ivl  = C_RST_REFRESH;
        hold_mult    = C_RST_HOLD;
        min_delay    = C_RST_DELAY;
        reinit_ticks = C_RST_REINIT;
        tx_state     = ST_INIT;
        refresh_left = '0;
        delay_left   = '0;
        shut_left    = '0;
        change_seen  = 1'b0;
        ttl_adv      = '0;
    endfunction

    function automatic void load_idle();
        logic [C_PROD_W-1:0] prod;
        prod = {{C_HOLD_W{1'b0}}, refresh_ivl} * {{C_TIMER_W{1'b0}}, hold_mult};
        ttl_adv      = (prod > {{C_HOLD_W{1'b0}}, C_TTL_MAX}) ? C_TTL_MAX : prod[C_TIMER_W-1:0];
        refresh_left = refresh_ivl;
        delay_left   = min_delay;
        change_seen  = 1'b0;
        tx_state     = ST_IDLE;
    endfunction

    // One tick: latch change, transition, state action, then count down.
    function automatic t_result advance_tick(input logic [1:0] admin, input logic change);
        logic    tx_on;
        t_result res;
        tx_on             = (admin == C_ADMIN_TX_ONLY) || (admin == C_ADMIN_RX_TX);
        res.send_info     = 1'b0;
        res.send_shutdown = 1'b0;
        if (change) begin
            change_seen = 1'b1;
        end
        case (tx_state)
            ST_INIT: begin
                if (tx_on) begin
                    load_idle();
                end
            end
            ST_IDLE: begin
                if (!tx_on) begin
                    tx_state          = ST_SHUT;
                    shut_left         = reinit_ticks;
                    res.send_shutdown = 1'b1;
                end else if (delay_left == '0 && (refresh_left == '0 || change_seen)) begin
                    tx_state      = ST_INFO;
                    res.send_info = 1'b1;
                end
            end
            ST_SHUT: begin
                if (shut_left == '0) begin
                    tx_state = ST_INIT;
                end
            end
            default: begin
                load_idle();
            end
        endcase
        if (tx_state == ST_INIT) begin
            change_seen = 1'b0;
            shut_left   = '0;
        end
        if (shut_left != '0) shut_left--;
        if (delay_left != '0) delay_left--;
        if (refresh_left != '0) refresh_left--;
        res.fsm_state = tx_state;
        res.ttl_value = ttl_adv;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            predicted_results.delete();
            mismatches = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    C_REG_REFRESH: refresh_ivl  = i_cfg.data;
                    C_REG_HOLD:    hold_mult    = i_cfg.data[C_HOLD_W-1:0];
                    C_REG_DELAY:   min_delay    = i_cfg.data;
                    C_REG_REINIT:  reinit_ticks = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: state %0d info %0b shutdown %0b ttl %0d",
                           i_result.fsm_state_out, i_result.send_info,
                           i_result.send_shutdown, i_result.ttl_value);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("fsm_state_out", 16'(want.fsm_state),
                                16'(i_result.fsm_state_out));
                    check_field("send_info", 16'(want.send_info), 16'(i_result.send_info));
                    check_field("send_shutdown", 16'(want.send_shutdown),
                                16'(i_result.send_shutdown));
                    check_field("ttl_value", want.ttl_value, i_result.ttl_value);
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                predicted_results.push_back(advance_tick(i_tick.admin_status,
                                                         i_tick.local_change));
            end
        end
        o_pending    <= predicted_results.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench top: stimulus, flow control and verdict for the LLDP transmit state machine.
`default_nettype none

module testbench;
    import lltx_pkg::*;

    // An index outside the register map; the write must leave every register alone.
    localparam logic [C_CFG_IDX_W-1:0] C_REG_UNUSED = 8'hA7;
    // Length of the forced result-side hold-off, in cycles.
    localparam int unsigned LONG_STALL = 300;
    localparam int unsigned PHASES     = 8;
    localparam int unsigned PHASE_TICKS = 100;

    logic clk = 1'b0;
    logic rst_n;

    lltx_tick_if   tick_ch();
    lltx_result_if result_ch();
    lltx_cfg_if    cfg_ch();

    int unsigned pending_results;
    int unsigned fail_count;

    // Idle percentages: the sender's is read only by the stimulus process,
    // the receiver's only by the ready process.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stalls_asked;

    always #6 clk = ~clk;

    lldp_transmit_fsm DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    lltx_scoreboard u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick       (tick_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending_results),
        .o_fail_count (fail_count)
    );

    // Result-side flow control. A long hold-off is requested by bumping
    // stalls_asked; count it down here so the sender keeps pushing meanwhile.
    initial begin
        int unsigned stall_left;
        int unsigned stalls_served;
        stall_left    = 0;
        stalls_served = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left != 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else if (stalls_served != stalls_asked) begin
                result_ch.ready <= 1'b0;
                stall_left = LONG_STALL;
                stalls_served++;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one tick request, idling first at the sender's rate. Leave valid
    // high afterwards so back-to-back requests never drop it in between.
    task automatic send_tick(input logic [C_ADMIN_W-1:0] admin, input logic change);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.admin_status <= admin;
        tick_ch.local_change <= change;
        do @(posedge clk); while (!tick_ch.ready);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write all four registers; hold is passed at full data width so that
    // bits above the register can be exercised.
    task automatic configure(input logic [15:0] refresh, input logic [15:0] hold,
                             input logic [15:0] delay, input logic [15:0] reinit);
        write_reg(C_REG_REFRESH, refresh);
        write_reg(C_REG_HOLD, hold);
        write_reg(C_REG_DELAY, delay);
        write_reg(C_REG_REINIT, reinit);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid and hold until every predicted result has come back. The
    // pending count is registered, so step the clock before looking at it.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    // Mostly transmit-enabled runs with random change pulses, broken up by
    // short disabled stretches to reach shutdown, plus a little raw noise.
    task automatic random_ticks(input int unsigned count);
        int unsigned         off_left;
        logic [C_ADMIN_W-1:0] admin;
        off_left = 0;
        repeat (count) begin
            if (off_left == 0 && $urandom_range(0, 99) < 8) begin
                off_left = $urandom_range(1, 8);
            end
            if (off_left != 0) begin
                admin = $urandom_range(0, 1) ? C_ADMIN_RX_ONLY : C_ADMIN_DISABLED;
                off_left--;
            end else begin
                admin = $urandom_range(0, 1) ? C_ADMIN_RX_TX : C_ADMIN_TX_ONLY;
            end
            if ($urandom_range(0, 99) < 5) begin
                admin = C_ADMIN_W'($urandom_range(0, 3));
            end
            send_tick(admin, $urandom_range(0, 99) < 20);
        end
    endtask

    initial begin
        #(12 * 300000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned phase;
        logic [15:0] refresh;
        logic [15:0] hold;
        logic [15:0] delay;
        logic [15:0] reinit;

        // Drive every input to a known value before reset.
        rst_n                <= 1'b0;
        tick_ch.valid        <= 1'b0;
        tick_ch.admin_status <= C_ADMIN_DISABLED;
        tick_ch.local_change <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= C_REG_REFRESH;
        cfg_ch.data          <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stalls_asked  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: stay in initialize while disabled, enter idle, fire an
        // info frame off a change pulse, then shut down and reinitialize.
        send_tick(C_ADMIN_DISABLED, 1'b0);
        send_tick(C_ADMIN_RX_ONLY, 1'b1);
        send_tick(C_ADMIN_TX_ONLY, 1'b0);
        send_tick(C_ADMIN_RX_TX, 1'b1);
        send_tick(C_ADMIN_RX_TX, 1'b0);
        send_tick(C_ADMIN_RX_TX, 1'b0);
        send_tick(C_ADMIN_TX_ONLY, 1'b0);
        send_tick(C_ADMIN_DISABLED, 1'b0);
        send_tick(C_ADMIN_RX_ONLY, 1'b0);
        send_tick(C_ADMIN_RX_ONLY, 1'b0);
        send_tick(C_ADMIN_DISABLED, 1'b0);
        drain();

        // Zero refresh, zero hold (upper data bits dropped), zero delay and
        // reinit; a write to an unmapped index must change nothing.
        write_reg(C_REG_UNUSED, 16'hFFFF);
        configure(16'd0, 16'h3C00, 16'd0, 16'd0);
        repeat (6) send_tick(C_ADMIN_RX_TX, 1'b0);
        send_tick(C_ADMIN_RX_ONLY, 1'b0);
        send_tick(C_ADMIN_DISABLED, 1'b0);
        send_tick(C_ADMIN_TX_ONLY, 1'b1);
        drain();

        // Random phases: sender light / receiver heavy idling, then the reverse, then
        // none. Phase 2 runs every register at its top value, phase 4 runs refresh
        // and hold at one and delay and reinit at zero; the rest pick mostly small timers.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 69;
            end else if (phase < 6) begin
                send_idle_pct = 69;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 2) begin
                configure(16'hFFFF, 16'h00FF, 16'hFFFF, 16'hFFFF);
            end else if (phase == 4) begin
                configure(16'd1, 16'd1, 16'd0, 16'd0);
            end else begin
                refresh = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(257, 1000))
                                                      : 16'($urandom_range(1, 12));
                hold    = 16'($urandom_range(1, 255));
                delay   = 16'($urandom_range(0, 4));
                reinit  = 16'($urandom_range(0, 6));
                configure(refresh, hold, delay, reinit);
            end
            // Stall the result side for a long stretch while ticks keep
            // coming, so the block backs up into its input.
            if (phase == 6) begin
                stalls_asked = stalls_asked + 1;
            end
            random_ticks(PHASE_TICKS);
            drain();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
